// ===== hdl/ahrb_pkg.sv =====
package ahrb_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 64;
    localparam int REQ_W    = 7;
    localparam int OFFS_W   = 6;
    localparam int CAP_W    = 17;

    // stream bus widths, fields packed from bit 0 and padded to whole bytes
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 160;

    // defaults for the top level parameters
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int MAX_READ_DEF    = 64;
    localparam int CAP_RESET       = 65536;

    // item kinds carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SETUP,
        ST_STREAM,
        ST_DRAIN,
        ST_MOD
    } t_ahrb_state;

    // one result beat as it moves through the read pipe
    typedef struct packed {
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
        logic [OFFS_W-1:0]   offset;
        logic                last;
    } t_ahrb_entry;

endpackage

// ===== hdl/ahrb_ram.sv =====
module ahrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ahrb_mod_unit.sv =====
module ahrb_mod_unit #(
    parameter int DIV_W = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ahrb_pkg::POS_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [DIV_W-1:0]           o_rem
);

    localparam int CNT_W = $clog2(ahrb_pkg::POS_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [ahrb_pkg::POS_W-1:0] r_dvd;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           r_div;
    logic [DIV_W:0]             w_trial;
    logic [DIV_W:0]             w_diff;
    logic                       w_ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[ahrb_pkg::POS_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(ahrb_pkg::POS_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== hdl/ahrb_out_buf.sv =====
module ahrb_out_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_issue,
    input  ahrb_pkg::t_ahrb_entry         i_meta,
    input  logic [ahrb_pkg::SAMPLE_W-1:0] i_rdata,
    input  logic                          i_ready,
    output logic                          o_valid,
    output ahrb_pkg::t_ahrb_entry         o_entry,
    output logic                          o_credit,
    output logic                          o_empty
);

    logic                  r_inflight;
    ahrb_pkg::t_ahrb_entry r_meta;
    logic                  r_head_v;
    logic                  r_skid_v;
    ahrb_pkg::t_ahrb_entry r_head;
    ahrb_pkg::t_ahrb_entry r_skid;
    logic                  n_head_v;
    logic                  n_skid_v;
    ahrb_pkg::t_ahrb_entry n_head;
    ahrb_pkg::t_ahrb_entry n_skid;
    ahrb_pkg::t_ahrb_entry w_new;
    logic                  w_pop;
    logic [1:0]            w_after;

    assign w_pop = r_head_v & i_ready;

    // beat coming back from the store, status beats carry a zero sample
    always_comb begin
        w_new = r_meta;
        w_new.sample = r_meta.sample_valid ? i_rdata : '0;
    end

    // room for one more read once the beats already owed are counted
    assign w_after  = 2'(r_head_v) + 2'(r_skid_v) + 2'(r_inflight) - 2'(w_pop);
    assign o_credit = (w_after < 2'd2);
    assign o_empty  = !r_head_v && !r_skid_v && !r_inflight;

    // head and skid update
    always_comb begin
        n_head_v = r_head_v;
        n_skid_v = r_skid_v;
        n_head   = r_head;
        n_skid   = r_skid;
        if (w_pop) begin
            if (r_skid_v) begin
                n_head   = r_skid;
                n_head_v = 1'b1;
                n_skid   = w_new;
                n_skid_v = r_inflight;
            end else begin
                n_head   = w_new;
                n_head_v = r_inflight;
            end
        end else if (!r_head_v) begin
            n_head   = w_new;
            n_head_v = r_inflight;
        end else if (r_inflight) begin
            n_skid   = w_new;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_head_v   <= 1'b0;
            r_skid_v   <= 1'b0;
        end else begin
            r_inflight <= i_issue;
            r_head_v   <= n_head_v;
            r_skid_v   <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_meta <= i_meta;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_valid = r_head_v;
    assign o_entry = r_head;

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_head_v, r_skid_v, r_inflight}) <= 2)
        else $error("read pipe holds more beats than it has room for");

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_head_v)
        else $error("skid entry held without a head entry");
`endif

endmodule

// ===== hdl/audio_history_ring_buffer_core.sv =====
// write item: taken in idle if no capacity beat waits, writes may follow back to back
// read item of n results: passes the calc and setup states, then results stream one per
// cycle from the store read port while the output is ready; next item after the drain
// capacity write: a bit-serial remainder rederives the write slot before the next beat
// reset: write count 0, capacity min(65536, store depth), samples undefined until written
module audio_history_ring_buffer_core #(
    parameter int STORE_DEPTH = ahrb_pkg::STORE_DEPTH_DEF,
    parameter int MAX_READ    = ahrb_pkg::MAX_READ_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: capacity
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ahrb_pkg::CAP_W-1:0]       i_cfg_data,
    // sample_in, start_pos, request_count
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ahrb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op
    input  logic                             i_s_axis_tuser,
    // sample_out, sample_offset, samples_read, next_read_position, overrun,
    // ahead_of_writer, write_position
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ahrb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // sample_valid
    output logic                             o_m_axis_tuser,
    output logic                             o_m_axis_tlast
);

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int CW      = AW + 1;
    localparam int REQ_W   = ahrb_pkg::REQ_W;
    localparam int POS_W   = ahrb_pkg::POS_W;
    localparam int CMP_W   = (CW > REQ_W) ? CW : REQ_W;
    localparam int CAP_RST = (ahrb_pkg::CAP_RESET > STORE_DEPTH) ?
                             STORE_DEPTH : ahrb_pkg::CAP_RESET;

    ahrb_pkg::t_ahrb_state r_state, n_state;

    logic [POS_W-1:0] r_wcount, n_wcount;
    logic [AW-1:0]    r_wslot, n_wslot;
    logic [CW-1:0]    r_cap, n_cap;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_diff, n_diff;
    logic [POS_W-1:0] r_rd_wpos, n_rd_wpos;
    logic [POS_W-1:0] r_nrp, n_nrp;
    logic [REQ_W-1:0] r_req, n_req;
    logic [REQ_W-1:0] r_n, n_n;
    logic [REQ_W-1:0] r_idx, n_idx;
    logic [AW-1:0]    r_slot, n_slot;
    logic             r_ahead, n_ahead;
    logic             r_ovr, n_ovr;

    logic                          w_in_acc;
    logic                          w_cfg_acc;
    logic                          w_op;
    logic [ahrb_pkg::SAMPLE_W-1:0] w_in_sample;
    logic [POS_W-1:0]              w_in_pos;
    logic [REQ_W-1:0]              w_in_req;
    logic [REQ_W-1:0]              w_req_sat;
    logic [CW-1:0]                 w_cap_eff;
    logic                          w_ovr;
    logic [CW-1:0]                 w_d;
    logic [REQ_W-1:0]              w_n;
    logic [POS_W-1:0]              w_base;
    logic [AW-1:0]                 w_start_slot;
    logic [AW-1:0]                 w_wslot_inc;
    logic [AW-1:0]                 w_slot_inc;
    logic                          w_we;
    logic                          w_issue;
    logic                          w_re;
    logic                          w_last_issue;
    ahrb_pkg::t_ahrb_entry         w_meta;
    ahrb_pkg::t_ahrb_entry         w_head;
    logic [ahrb_pkg::SAMPLE_W-1:0] w_rdata;
    logic                          w_credit;
    logic                          w_buf_empty;
    logic                          w_mod_done;
    logic [CW-1:0]                 w_mod_rem;

    // input beat fields
    assign w_op        = i_s_axis_tuser;
    assign w_in_sample = i_s_axis_tdata[15:0];
    assign w_in_pos    = i_s_axis_tdata[79:16];
    assign w_in_req    = i_s_axis_tdata[86:80];
    assign w_req_sat   = (w_in_req > REQ_W'(MAX_READ)) ? REQ_W'(MAX_READ) : w_in_req;

    assign o_cfg_ready     = (r_state == ahrb_pkg::ST_IDLE);
    assign o_s_axis_tready = (r_state == ahrb_pkg::ST_IDLE) && !i_cfg_valid;
    assign w_cfg_acc       = i_cfg_valid & o_cfg_ready;
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;

    // capacity clamped to 1 .. store depth
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cap_eff = CW'(1);
        end else if (32'(i_cfg_data) > 32'(STORE_DEPTH)) begin
            w_cap_eff = CW'(STORE_DEPTH);
        end else begin
            w_cap_eff = CW'(i_cfg_data);
        end
    end

    // slot increments with wrap at capacity
    assign w_wslot_inc = (({1'b0, r_wslot} + CW'(1)) == r_cap) ? '0 : r_wslot + AW'(1);
    assign w_slot_inc  = (({1'b0, r_slot} + CW'(1)) == r_cap) ? '0 : r_slot + AW'(1);

    // overrun check, run length and start slot relative to the write slot
    assign w_ovr  = !r_ahead && (r_diff > POS_W'(r_cap));
    assign w_d    = w_ovr ? r_cap : r_diff[CW-1:0];
    assign w_n    = r_ahead ? '0 :
                    ((CMP_W'(w_d) < CMP_W'(r_req)) ? REQ_W'(w_d) : r_req);
    assign w_base = w_ovr ? (r_rd_wpos - POS_W'(r_cap)) : r_pos;

    always_comb begin
        if ({1'b0, r_wslot} >= w_d) begin
            w_start_slot = AW'({1'b0, r_wslot} - w_d);
        end else begin
            w_start_slot = AW'({1'b0, r_wslot} + r_cap - w_d);
        end
    end

    // read issue into the output pipe
    assign w_issue      = (r_state == ahrb_pkg::ST_STREAM) && w_credit;
    assign w_re         = w_issue && (r_n != '0);
    assign w_last_issue = (r_n == '0) || ((r_idx + REQ_W'(1)) == r_n);

    always_comb begin
        w_meta.sample_valid = (r_n != '0);
        w_meta.sample       = '0;
        w_meta.offset       = r_idx[ahrb_pkg::OFFS_W-1:0];
        w_meta.last         = w_last_issue;
    end

    assign w_we = w_in_acc && (w_op == ahrb_pkg::OP_WRITE);

    // sequencer: next state and register updates
    always_comb begin
        n_state   = r_state;
        n_wcount  = r_wcount;
        n_wslot   = r_wslot;
        n_cap     = r_cap;
        n_pos     = r_pos;
        n_diff    = r_diff;
        n_rd_wpos = r_rd_wpos;
        n_nrp     = r_nrp;
        n_req     = r_req;
        n_n       = r_n;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_ahead   = r_ahead;
        n_ovr     = r_ovr;
        case (r_state)
            ahrb_pkg::ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_cap   = w_cap_eff;
                    n_state = ahrb_pkg::ST_MOD;
                end else if (w_in_acc) begin
                    if (w_op == ahrb_pkg::OP_WRITE) begin
                        n_wcount = r_wcount + POS_W'(1);
                        n_wslot  = w_wslot_inc;
                    end else begin
                        n_pos     = w_in_pos;
                        n_req     = w_req_sat;
                        n_diff    = r_wcount - w_in_pos;
                        n_ahead   = (w_in_pos > r_wcount);
                        n_rd_wpos = r_wcount;
                        n_state   = ahrb_pkg::ST_CALC;
                    end
                end
            end
            ahrb_pkg::ST_CALC: begin
                n_ovr   = w_ovr;
                n_n     = w_n;
                n_pos   = w_base;
                n_slot  = w_start_slot;
                n_state = ahrb_pkg::ST_SETUP;
            end
            ahrb_pkg::ST_SETUP: begin
                n_nrp   = r_pos + POS_W'(r_n);
                n_idx   = '0;
                n_state = ahrb_pkg::ST_STREAM;
            end
            ahrb_pkg::ST_STREAM: begin
                if (w_issue) begin
                    n_idx  = r_idx + REQ_W'(1);
                    n_slot = w_slot_inc;
                    if (w_last_issue) begin
                        n_state = ahrb_pkg::ST_DRAIN;
                    end
                end
            end
            ahrb_pkg::ST_DRAIN: begin
                if (w_buf_empty) begin
                    n_state = ahrb_pkg::ST_IDLE;
                end
            end
            ahrb_pkg::ST_MOD: begin
                if (w_mod_done) begin
                    n_wslot = w_mod_rem[AW-1:0];
                    n_state = ahrb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ahrb_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ahrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // writer state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount <= '0;
            r_wslot  <= '0;
            r_cap    <= CW'(CAP_RST);
        end else begin
            r_wcount <= n_wcount;
            r_wslot  <= n_wslot;
            r_cap    <= n_cap;
        end
    end

    // read request working registers
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_diff    <= n_diff;
        r_rd_wpos <= n_rd_wpos;
        r_nrp     <= n_nrp;
        r_req     <= n_req;
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_ahead   <= n_ahead;
        r_ovr     <= n_ovr;
    end

    ahrb_ram #(
        .WIDTH (ahrb_pkg::SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wslot),
        .i_wdata (w_in_sample),
        .i_re    (w_re),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    ahrb_mod_unit #(
        .DIV_W (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cfg_acc),
        .i_dividend (r_wcount),
        .i_divisor  (w_cap_eff),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    ahrb_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (w_issue),
        .i_meta   (w_meta),
        .i_rdata  (w_rdata),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_entry  (w_head),
        .o_credit (w_credit),
        .o_empty  (w_buf_empty)
    );

    // result beat
    assign o_m_axis_tdata = {1'b0, r_rd_wpos, r_ahead, r_ovr, r_nrp, r_n,
                             w_head.offset, w_head.sample};
    assign o_m_axis_tuser = w_head.sample_valid;
    assign o_m_axis_tlast = w_head.last;

`ifndef ASSERT_OFF
    a_wslot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ahrb_pkg::ST_MOD) |-> ({1'b0, r_wslot} < r_cap))
        else $error("write slot outside capacity");

    a_write_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_wcount == $past(r_wcount) + POS_W'(1)))
        else $error("write count did not advance on a write beat");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ahrb_pkg::ST_STREAM) && (r_n != '0)) |-> (r_idx < r_n))
        else $error("read index beyond run length");
`endif

endmodule
